// ===== sv/psrq_pkg.sv =====
package psrq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF   = 16;
  localparam int unsigned TASK_ID_BITS_DEF  = 8;
  localparam int unsigned PRIORITY_BITS_DEF = 8;
  localparam int unsigned STATUS_BITS       = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2
  } status_e;

  // update command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } op_t;

endpackage

// ===== sv/psrq_in_if.sv =====
interface psrq_in_if #(
  parameter int unsigned IdBits   = 8,
  parameter int unsigned PrioBits = 8
);
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [IdBits-1:0]   task_id;
  logic [PrioBits-1:0] task_priority;

  modport source (output valid, output opcode, output task_id, output task_priority,
                  input ready);
  modport sink   (input valid, input opcode, input task_id, input task_priority,
                  output ready);
endinterface

// ===== sv/psrq_out_if.sv =====
interface psrq_out_if #(
  parameter int unsigned IdBits   = 8,
  parameter int unsigned PrioBits = 8,
  parameter int unsigned CntBits  = 5
);
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic                head_valid;
  logic [IdBits-1:0]   head_task_id;
  logic [PrioBits-1:0] head_priority;
  logic [CntBits-1:0]  task_count;

  modport source (output valid, output status, output head_valid, output head_task_id,
                  output head_priority, output task_count, input ready);
  modport sink   (input valid, input status, input head_valid, input head_task_id,
                  input head_priority, input task_count, output ready);
endinterface

// ===== sv/priority_sorted_ready_queue.sv =====
// a result is registered and offered in the cycle after its item is transferred
// throughput: one insert or remove per cycle while the sink takes each result; every slot cell shifts in parallel,
//   each cell finds the insert point from its own slot, the first id match ripples along the row of cells
// a pending result does not block the next item when the sink takes it that cycle
// reset: all slots empty, count zero, no result pending
module priority_sorted_ready_queue import psrq_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF,
  parameter int unsigned IdBits     = TASK_ID_BITS_DEF,
  parameter int unsigned PrioBits   = PRIORITY_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  psrq_in_if.sink     req_i,
  psrq_out_if.source  rsp_o
);

  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  logic                valid_w [QueueDepth];
  logic [IdBits-1:0]   id_w    [QueueDepth];
  logic [PrioBits-1:0] prio_w  [QueueDepth];
  logic                before_w[QueueDepth+1];
  logic                hit_w   [QueueDepth+1];
  logic [QueueDepth-1:0] valid_vec;

  logic               rsp_valid_q;
  status_e            status_q, status_d;
  logic [CntBits-1:0] count_q, count_d;

  logic transfer, is_remove, full, found;
  op_t  op;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign transfer    = req_i.valid && req_i.ready;
  assign is_remove   = (req_i.opcode == OP_REMOVE);
  assign full        = valid_w[QueueDepth-1];
  assign found       = hit_w[QueueDepth];

  assign op.ins = transfer && !is_remove && !full;
  assign op.rem = transfer && is_remove && found;

  assign before_w[0] = 1'b0;
  assign hit_w[0]    = 1'b0;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic                lv, rv;
    logic [IdBits-1:0]   lid, rid;
    logic [PrioBits-1:0] lpr, rpr;

    if (i == 0) begin : g_left_edge
      assign lv  = 1'b0;
      assign lid = '0;
      assign lpr = '0;
    end else begin : g_left
      assign lv  = valid_w[i-1];
      assign lid = id_w[i-1];
      assign lpr = prio_w[i-1];
    end

    if (i == QueueDepth - 1) begin : g_right_edge
      assign rv  = 1'b0;
      assign rid = '0;
      assign rpr = '0;
    end else begin : g_right
      assign rv  = valid_w[i+1];
      assign rid = id_w[i+1];
      assign rpr = prio_w[i+1];
    end

    psrq_cell #(
      .IdBits   (IdBits),
      .PrioBits (PrioBits)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (op),
      .new_id_i      (req_i.task_id),
      .new_prio_i    (req_i.task_priority),
      .left_valid_i  (lv),
      .left_id_i     (lid),
      .left_prio_i   (lpr),
      .right_valid_i (rv),
      .right_id_i    (rid),
      .right_prio_i  (rpr),
      .before_i      (before_w[i]),
      .hit_i         (hit_w[i]),
      .before_o      (before_w[i+1]),
      .hit_o         (hit_w[i+1]),
      .valid_o       (valid_w[i]),
      .id_o          (id_w[i]),
      .prio_o        (prio_w[i])
    );

    assign valid_vec[i] = valid_w[i];
  end

  always_comb begin
    status_d = STAT_OK;
    count_d  = count_q;
    if (is_remove) begin
      if (found) begin
        count_d = count_q - CntBits'(1);
      end else begin
        status_d = STAT_MISSING;
      end
    end else begin
      if (full) begin
        status_d = STAT_FULL;
      end else begin
        count_d = count_q + CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      count_q     <= '0;
      status_q    <= STAT_OK;
    end else begin
      if (transfer) begin
        rsp_valid_q <= 1'b1;
        count_q     <= count_d;
        status_q    <= status_d;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // slots change only on an input transfer, which also reloads the result,
  // so the head cell matches the pending result
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.head_valid    = valid_w[0];
  assign rsp_o.head_task_id  = valid_w[0] ? id_w[0] : '0;
  assign rsp_o.head_priority = valid_w[0] ? prio_w[0] : '0;
  assign rsp_o.task_count    = count_q;

  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("slot count differs from occupied cells");

  a_valid_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("occupied slots are not contiguous from the head");

  a_full_refused : assert property (@(posedge clk_i) disable iff (!rst_ni)
    transfer && !is_remove && full |=> status_q == STAT_FULL && $stable(valid_vec))
    else $error("insert into full queue changed state");

  a_missing_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    transfer && is_remove && !found |=> status_q == STAT_MISSING && $stable(count_q))
    else $error("remove of absent id changed count");

endmodule

// ===== sv/psrq_cell.sv =====
module psrq_cell import psrq_pkg::*; #(
  parameter int unsigned IdBits   = TASK_ID_BITS_DEF,
  parameter int unsigned PrioBits = PRIORITY_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  op_t                 op_i,
  input  logic [IdBits-1:0]   new_id_i,
  input  logic [PrioBits-1:0] new_prio_i,
  input  logic                left_valid_i,
  input  logic [IdBits-1:0]   left_id_i,
  input  logic [PrioBits-1:0] left_prio_i,
  input  logic                right_valid_i,
  input  logic [IdBits-1:0]   right_id_i,
  input  logic [PrioBits-1:0] right_prio_i,
  input  logic                before_i,
  input  logic                hit_i,
  output logic                before_o,
  output logic                hit_o,
  output logic                valid_o,
  output logic [IdBits-1:0]   id_o,
  output logic [PrioBits-1:0] prio_o
);

  logic                valid_q, valid_d;
  logic [IdBits-1:0]   id_q, id_d;
  logic [PrioBits-1:0] prio_q, prio_d;

  // new task belongs at or ahead of this slot
  assign before_o = !valid_q || (new_prio_i < prio_q);
  // first matching id at or ahead of this slot
  assign hit_o    = hit_i || (valid_q && (id_q == new_id_i));

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    prio_d  = prio_q;
    if (op_i.ins) begin
      if (before_i) begin
        valid_d = left_valid_i;
        id_d    = left_id_i;
        prio_d  = left_prio_i;
      end else if (before_o) begin
        valid_d = 1'b1;
        id_d    = new_id_i;
        prio_d  = new_prio_i;
      end
    end else if (op_i.rem && hit_o) begin
      valid_d = right_valid_i;
      id_d    = right_id_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign prio_o  = prio_q;

endmodule
